// ===== rtl/core/bccc_pkg.sv =====
`default_nettype none

package bccc_pkg;

    // width of the codes_seen result field
    localparam int CODES_W = 13;

    // result words the output queue can hold
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic                 all_present;
        logic [CODES_W-1:0]   codes_seen;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_code_coverage_checker.sv =====
`default_nettype none

// Result: a string's word is formed in stage 1 from its last bit and registered into the output queue.
// Throughput: one bit per cycle while in_stall is low, set by the single read-modify-write per bit on the
//   code map (one read port, one write port, registered read).
// Reset: the code map is swept to zero, every address in turn, with in_stall high; the same
//   sweep reruns after every 2^EPOCH_W-1 strings when the epoch tag wraps.
// Config writes are taken in every cycle, cfg_ready is tied high.
module binary_code_coverage_checker #(
    parameter int K_MAX   = 12,
    parameter int EPOCH_W = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    // bit stream in
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        data_bit,
    input  wire logic        last_bit,
    // result out
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             all_present,
    output logic [bccc_pkg::CODES_W-1:0] codes_seen
);

    localparam int ADDR_W = K_MAX;
    localparam int CNT_W  = K_MAX + 1;
    localparam int KW     = $clog2(K_MAX + 1);

    // ------------------------------------------------------------------
    // Config register: code length k
    // ------------------------------------------------------------------
    logic [3:0]    code_length_reg;
    logic [KW-1:0] k_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            code_length_reg <= cfg_data;
        end
    end

    // clamp k to 1..K_MAX
    always_comb
    begin
        if (code_length_reg == 4'd0)
        begin
            k_eff = KW'(1);
        end
        else if (32'(code_length_reg) > K_MAX)
        begin
            k_eff = KW'(K_MAX);
        end
        else
        begin
            k_eff = KW'(code_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: shift window, fill count, code, map read issue
    // ------------------------------------------------------------------
    logic               accept;
    logic [ADDR_W-1:0]  window_reg;
    logic [ADDR_W-1:0]  window_next;
    logic [KW-1:0]      fill_reg;
    logic [KW-1:0]      fill_next;
    logic [ADDR_W-1:0]  code_mask;
    logic [ADDR_W-1:0]  code;
    logic               mark;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               clear_start;
    logic               map_busy;

    assign accept      = in_valid && !in_stall;
    assign window_next = (window_reg << 1) | ADDR_W'(data_bit);
    assign fill_next   = (32'(fill_reg) < K_MAX) ? fill_reg + KW'(1) : fill_reg;
    assign code_mask   = ~({ADDR_W{1'b1}} << k_eff);
    assign code        = window_next & code_mask;
    assign mark        = (fill_next >= k_eff);
    // all epoch tags used up: sweep the map once this string is closed
    assign clear_start = accept && last_bit && (epoch_reg == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            epoch_reg  <= EPOCH_W'(1);
        end
        else if (accept)
        begin
            if (last_bit)
            begin
                window_reg <= '0;
                fill_reg   <= '0;
                // tag 0 is what the sweep writes, never a live epoch
                epoch_reg  <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
            end
            else
            begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: map lookup result, distinct counter, write-back
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_mark_reg;
    logic               s1_last_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [EPOCH_W-1:0] s1_epoch_reg;
    logic [EPOCH_W-1:0] map_rd_data;
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic               seen;
    logic               new_code;
    logic               s1_we;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               res_push;
    bccc_pkg::result_t  res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mark_reg  <= mark;
            s1_last_reg  <= last_bit;
            s1_addr_reg  <= code;
            s1_epoch_reg <= epoch_reg;
        end
    end

    // The write of the previous word lands on the same edge as this word's read,
    // so the read misses it; forward that write. A last bit never writes, so a
    // forwarded hit always belongs to the same string.
    assign seen     = (map_rd_data == s1_epoch_reg)
                   || (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg));
    assign new_code = s1_valid_reg && s1_mark_reg && !seen;
    // old marks go stale with the epoch change, no need to mark on the last bit
    assign s1_we      = new_code && !s1_last_reg;
    assign count_next = count_reg + CNT_W'(new_code);
    assign res_push   = s1_valid_reg && s1_last_reg;

    assign res_word.all_present = (count_next == (CNT_W'(1) << k_eff));
    assign res_word.codes_seen  = bccc_pkg::CODES_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= s1_we;
            if (res_push)
            begin
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_addr_reg;
    end

    bccc_seen_map #(
        .ADDR_W (ADDR_W),
        .DATA_W (EPOCH_W)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .busy        (map_busy),
        .rd_en       (accept),
        .rd_addr     (code),
        .rd_data     (map_rd_data),
        .wr_en       (s1_we),
        .wr_addr     (s1_addr_reg),
        .wr_data     (s1_epoch_reg)
    );

    // ------------------------------------------------------------------
    // Result queue and input back-pressure
    // ------------------------------------------------------------------
    logic [1:0]        fifo_count;
    logic [2:0]        res_pending;
    bccc_pkg::result_t out_word;

    // words queued plus the one in stage 1 must leave room for one more
    assign res_pending = 3'(fifo_count) + 3'(res_push);
    assign in_stall    = map_busy || (res_pending >= 3'(bccc_pkg::OUT_DEPTH));

    bccc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_word),
        .count     (fifo_count)
    );

    assign all_present = out_word.all_present;
    assign codes_seen  = out_word.codes_seen;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        map_busy |-> !s1_we)
        else $error("map write during clear sweep");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (CNT_W'(1) << K_MAX))
        else $error("distinct count beyond map size");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_epoch_reg != '0))
        else $error("word tagged with sweep epoch");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (fifo_count != 2'(bccc_pkg::OUT_DEPTH)))
        else $error("result pushed into full queue");

endmodule

`default_nettype wire

// ===== rtl/core/bccc_seen_map.sv =====
`default_nettype none

module bccc_seen_map #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear_start,
    output logic                   busy,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0]      rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] map_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_data;

    // clear sweep owns the write port while busy
    always_comb
    begin
        if (busy_reg)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_reg;
            mem_data = '0;
        end
        else
        begin
            mem_we   = wr_en;
            mem_addr = wr_addr;
            mem_data = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_start)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == '1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bccc_out_fifo.sv =====
`default_nettype none

module bccc_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bccc_pkg::result_t push_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bccc_pkg::result_t      out_data,
    output logic [1:0]             count
);

    bccc_pkg::result_t slot_reg [bccc_pkg::OUT_DEPTH];
    logic [1:0]        rd_ptr_reg;
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        count_reg;
    logic              pop;

    assign pop = (count_reg != 2'd0) && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers wrap at the last slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(bccc_pkg::OUT_DEPTH - 1)) ? 2'd0
                                                                          : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(bccc_pkg::OUT_DEPTH - 1)) ? 2'd0
                                                                          : rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== tb/binary_code_coverage_checker_tb.sv =====
`timescale 1ns / 100ps

module binary_code_coverage_checker_tb;

    // must match the DUT default
    localparam int K_MAX = 12;
    localparam int MAP_SIZE = 1 << K_MAX;
    // short epoch tag so the wrap sweep comes round every 15 strings
    localparam int EPOCH_W = 4;
    // input words to send
    localparam int N_BITS = 1500;
    // longest hold-off either side draws per word
    localparam int MAX_GAP = 14;
    // extra quiet wait once no result word is owed, for bits still in the pipe
    localparam int DRAIN_CYCLES = 6;

    // ------------------------------------------------------------------
    // Coverage tally: mirrors the window / fill / code map / distinct
    // count of the DUT and queues the result word each string must give.
    // ------------------------------------------------------------------
    class code_tally;
        bit [3:0]            length_reg;
        bit [11:0]           window;
        int unsigned         fill;
        bit                  seen_map [MAP_SIZE];
        bit [12:0]           distinct;
        bccc_pkg::result_t   expected_words [$];
        int unsigned         failures;

        function new();
            length_reg = 4'd1;
            failures   = 0;
            clear_string();
        endfunction

        function void clear_string();
            window   = '0;
            fill     = 0;
            distinct = '0;
            foreach (seen_map[i])
                seen_map[i] = 1'b0;
        endfunction

        // register value clamped to 1..K_MAX
        function int unsigned code_bits();
            int unsigned k;
            k = 32'(length_reg);
            if (k < 1)
                k = 1;
            if (k > K_MAX)
                k = K_MAX;
            return k;
        endfunction

        function void set_length(bit [3:0] v);
            length_reg = v;
        endfunction

        function int unsigned outstanding();
            return expected_words.size();
        endfunction

        // one accepted bit; a last bit closes the string and queues its word
        function void take_bit(bit d, bit l);
            int unsigned       k;
            int unsigned       mask;
            int unsigned       code;
            bccc_pkg::result_t w;
            k = code_bits();
            mask = (1 << k) - 1;
            window = {window[10:0], d};
            if (fill < K_MAX)
                fill++;
            if (fill >= k)
            begin
                code = 32'(window) & mask;
                if (!seen_map[code[11:0]])
                begin
                    seen_map[code[11:0]] = 1'b1;
                    distinct++;
                end
            end
            if (l)
            begin
                w.all_present = (32'(distinct) == (1 << k));
                w.codes_seen  = distinct;
                expected_words.insert(expected_words.size(), w);
                clear_string();
            end
        endfunction

        function void check_word(logic ap, logic [bccc_pkg::CODES_W-1:0] cs);
            bccc_pkg::result_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: all_present %0d codes_seen %0d", ap, cs);
                failures++;
                return;
            end
            w = expected_words.pop_front();
            if (ap !== w.all_present)
            begin
                $error("all_present: expected %0d actual %0d", w.all_present, ap);
                failures++;
            end
            if (cs !== w.codes_seen)
            begin
                $error("codes_seen: expected %0d actual %0d", w.codes_seen, cs);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b1;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [3:0]                   cfg_data = 4'd0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         data_bit = 1'b0;
    logic                         last_bit = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         all_present;
    logic [bccc_pkg::CODES_W-1:0] codes_seen;

    code_tally   tally = new();
    // calm: neither side idles, to get back-to-back words through
    bit          calm = 1'b0;
    int unsigned bits_sent = 0;

    always #4 clk = ~clk;

    binary_code_coverage_checker #(
        .EPOCH_W (EPOCH_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_bit    (data_bit),
        .last_bit    (last_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .all_present (all_present),
        .codes_seen  (codes_seen)
    );

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with NBAs right after the rising edge
    // and sampled in the active region of the edge, i.e. pre-edge values.
    // ------------------------------------------------------------------

    // One bit word. A zero gap keeps in_valid high across words so the
    // step sees only the payload update, never a lower-then-raise.
    task automatic send_bit(input bit d, input bit l);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_bit <= d;
        last_bit <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tally.take_bit(d, l);
        bits_sent++;
    endtask

    // seq[from..upto-1]; flag the final one as last when ends is set
    task automatic send_bits(input bit seq [$], input int from, input int upto,
                             input bit ends);
        for (int i = from; i < upto; i++)
            send_bit(seq[i], ends && (i == upto - 1));
    endtask

    // Register write, only with the pipe drained. Results may still be
    // owed from earlier strings, and bits of an open string may still be
    // in the map update, so wait for both.
    task automatic write_length(input bit [3:0] v);
        in_valid <= 1'b0;
        while (tally.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tally.set_length(v);
    endtask

    // Prefer-one construction: starts with k zeros and yields every
    // k-bit code exactly once in 2^k + k - 1 bits.
    function automatic void build_de_bruijn(input int unsigned k, ref bit seq [$]);
        bit          used [MAP_SIZE];
        int unsigned cur;
        int unsigned nxt;
        int unsigned mask;
        bit          done;
        seq.delete();
        mask = (1 << k) - 1;
        repeat (k) seq.insert(seq.size(), 1'b0);
        cur = 0;
        used[0] = 1'b1;
        done = 1'b0;
        while (!done)
        begin
            nxt = ((cur << 1) | 1) & mask;
            if (used[nxt[11:0]])
                nxt = (cur << 1) & mask;
            if (used[nxt[11:0]])
                done = 1'b1;
            else
            begin
                seq.insert(seq.size(), nxt[0]);
                used[nxt[11:0]] = 1'b1;
                cur = nxt;
            end
        end
    endfunction

    function automatic void build_random(input int unsigned len, ref bit seq [$]);
        seq.delete();
        repeat (len) seq.insert(seq.size(), 1'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------
    // Result side: per word a random stall, then take it.
    // Stall is drawn regardless of out_valid so it lands on every phase.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            tally.check_word(all_present, codes_seen);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        bit          seq [$];
        int unsigned k;
        int unsigned kind;
        int unsigned cut;
        int unsigned n_strings;
        bit [3:0]    v;

        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // reset length is 1: lone zero sees one code of two
        seq = {1'b0};
        send_bits(seq, 0, 1, 1'b1);
        // both codes for k = 1
        seq = {1'b0, 1'b1};
        send_bits(seq, 0, 2, 1'b1);
        // zero clamps to 1
        write_length(4'd0);
        seq = {1'b1};
        send_bits(seq, 0, 1, 1'b1);
        // top of the register clamps to K_MAX; string too short for a code
        write_length(4'd15);
        seq = {1'b1, 1'b1, 1'b0};
        send_bits(seq, 0, 3, 1'b1);
        // widest legal code, single bit
        write_length(4'd12);
        seq = {1'b0};
        send_bits(seq, 0, 1, 1'b1);
        // full cover at k = 2
        write_length(4'd2);
        build_de_bruijn(2, seq);
        send_bits(seq, 0, seq.size(), 1'b1);
        // length changes mid-string: old flags stay counted
        write_length(4'd3);
        seq = {1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        send_bits(seq, 0, 3, 1'b0);
        write_length(4'd1);
        send_bits(seq, 3, 5, 1'b1);

        // --- random ---
        // Well-formed cover strings and random strings of up to k + 8 bits,
        // some broken covers and mid-string length changes. The short
        // epoch tag makes the wrap sweep recur within the run.
        while (bits_sent < N_BITS)
        begin
            case ($urandom_range(0, 9))
                0:       v = 4'($urandom_range(0, 15));
                1:       v = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(12, 15));
                2:       v = 4'($urandom_range(7, 12));
                default: v = 4'($urandom_range(1, 6));
            endcase
            write_length(v);
            calm = ($urandom_range(0, 3) == 0);
            k = tally.code_bits();
            n_strings = $urandom_range(5, 30);
            for (int s = 0; s < n_strings && bits_sent < N_BITS; s++)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 3 && k <= 8)
                begin
                    build_de_bruijn(k, seq);
                    if (kind == 2)
                    begin
                        // truncated cover
                        cut = $urandom_range(1, seq.size() - 1);
                        repeat (cut) seq.delete(seq.size() - 1);
                    end
                    else if (kind == 3)
                    begin
                        // one bit flipped
                        cut = $urandom_range(0, seq.size() - 1);
                        seq[cut] = ~seq[cut];
                    end
                end
                else if ($urandom_range(0, 3) == 0)
                    build_random($urandom_range(1, k), seq);
                else
                    build_random($urandom_range(1, k + 8), seq);

                if (kind == 4 && seq.size() >= 2)
                begin
                    // split the string around a register write
                    cut = $urandom_range(1, seq.size() - 1);
                    send_bits(seq, 0, cut, 1'b0);
                    write_length(4'($urandom_range(0, 15)));
                    k = tally.code_bits();
                    send_bits(seq, cut, seq.size(), 1'b1);
                end
                else
                    send_bits(seq, 0, seq.size(), 1'b1);
            end
        end

        // drain: all words back, then a few quiet cycles for strays
        in_valid <= 1'b0;
        while (tally.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (tally.failures == 0)
            $display("binary_code_coverage_checker: match");
        else
            $display("binary_code_coverage_checker: mismatch");
        $finish;
    end

    // hard stop: even with every sweep and stall the run needs a few ms at most
    initial
    begin
        #20_000_000;
        $display("binary_code_coverage_checker: mismatch");
        $finish;
    end

endmodule
